>>> src/click_sound_synthesizer_assert.svh
// Assertion macros for the click sound synthesizer.
// Each macro takes a label, a condition and a consequence, and
// checks them on i_clk with i_rst_n low disabling the check.
`ifndef CLICK_SOUND_SYNTHESIZER_ASSERT_SVH
`define CLICK_SOUND_SYNTHESIZER_ASSERT_SVH
`ifndef SYNTHESIS
`define CSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("click synth assertion failed");
`define CSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("click synth assertion failed");
`else
`define CSS_ASSERT_NOW(label, ante, cons)
`define CSS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

>>> src/css_pkg.sv
package css_pkg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TICK,
        S_MIX1,
        S_MIX2,
        S_MIX3,
        S_MAG,
        S_ENV,
        S_GAIN,
        S_DONE
    } t_state;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_REQ   = 2'd1;
    localparam logic [1:0] OP_STOP  = 2'd2;

    localparam int unsigned APB_AW = 3;
    localparam logic [APB_AW-1:0] ADDR_MUTE = 3'd0;

    localparam int unsigned INTENSITY_LEVELS = 256;
    localparam logic [14:0] NOISE_START = 15'd10000;

    function automatic longint unsigned f_tm(longint unsigned q);
        return 64'd983 + (q * 64'd2949 + 64'd127) / 64'd255;
    endfunction

    function automatic longint unsigned f_nw(longint unsigned q);
        return ((64'd16384 - f_tm(q)) * 64'd15565 + 64'd8192) >> 14;
    endfunction

    function automatic longint unsigned f_gain(longint unsigned q);
        return 64'd24576 + (q * 64'd9830 + 64'd127) / 64'd255;
    endfunction

    function automatic longint unsigned f_step(longint unsigned q);
        return 64'd175304788 + (q * 64'd331131265 + 64'd127) / 64'd255;
    endfunction

endpackage

>>> src/css_ram.sv
module css_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/click_sound_synthesizer.sv
// A tick word that plays a click sample goes through S_TICK, S_MIX1, S_MIX2, S_MIX3,
// S_MAG, S_ENV, S_GAIN and S_DONE into the output register, an idle or silence-tail
// tick from S_TICK straight to S_DONE; requests and stop give no word.
// A word is taken only in S_IDLE, so a tick must finish before the next is accepted;
// the multiply chain (mix, envelope, gain) is walked one stage per cycle.
// Reset (synchronous, active low) clears mute, queue pointers and playback state;
// the queue RAM keeps its contents and is only read where written.
`include "click_sound_synthesizer_assert.svh"
module click_sound_synthesizer
    import css_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH      = 16,
    parameter int unsigned CLICK_LENGTH     = 176,
    parameter int unsigned TAIL_LENGTH      = 1764,
    parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_opcode,
    input  logic [7:0]         i_intensity,
    input  logic [14:0]        i_noise_draw,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_sample,
    output logic               o_click_active,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int unsigned QW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned IW = $clog2(CLICK_LENGTH + TAIL_LENGTH + 1);
    localparam int unsigned EW = $clog2(CLICK_LENGTH);
    localparam int unsigned SW = $clog2(SINE_TABLE_DEPTH);
    localparam longint unsigned TwoPiQ30 = 64'd6746518852;
    localparam longint unsigned OneQ30 = 64'd1 << 30;

    // exp(-11*n/CLICK_LENGTH) in Q0.16
    function automatic logic [15:0] f_env(longint unsigned Idx);
        longint unsigned Z, Sum, Term, E;
        Z = ((64'd11 * Idx) << 30) / (CLICK_LENGTH * 16);
        Sum = OneQ30;
        Term = OneQ30;
        for (longint unsigned K = 1; K <= 20; K++) begin
            Term = ((Term * Z) >> 30) / K;
            Sum = Sum + Term;
        end
        E = (64'd1 << 60) / Sum;
        for (int J = 0; J < 4; J++) begin
            E = (E * E + (64'd1 << 29)) >> 30;
        end
        E = (E + (64'd1 << 13)) >> 14;
        if (E > 64'd65535) begin
            E = 64'd65535;
        end
        return E[15:0];
    endfunction

    function automatic logic signed [15:0] f_sine(longint unsigned Kidx);
        longint unsigned T, A, X, X2, R, S;
        logic Neg;
        T = (Kidx << 32) / SINE_TABLE_DEPTH;
        if (T < (64'd1 << 30)) begin
            A = T;
            Neg = 1'b0;
        end else if (T <= (64'd1 << 31)) begin
            A = (64'd1 << 31) - T;
            Neg = 1'b0;
        end else if (T < (64'd3 << 30)) begin
            A = T - (64'd1 << 31);
            Neg = 1'b1;
        end else begin
            A = (64'd1 << 32) - T;
            Neg = 1'b1;
        end
        X = (A * TwoPiQ30) >> 32;
        X2 = (X * X) >> 30;
        R = OneQ30;
        R = OneQ30 - ((X2 * R) >> 30) / 110;
        R = OneQ30 - ((X2 * R) >> 30) / 72;
        R = OneQ30 - ((X2 * R) >> 30) / 42;
        R = OneQ30 - ((X2 * R) >> 30) / 20;
        R = OneQ30 - ((X2 * R) >> 30) / 6;
        S = (X * R) >> 30;
        S = (S + (64'd1 << 14)) >> 15;
        if (S > 64'd32767) begin
            S = 64'd32767;
        end
        return Neg ? -signed'(S[15:0]) : signed'(S[15:0]);
    endfunction

    // constant tables
    logic        [15:0] w_env  [CLICK_LENGTH];
    logic signed [15:0] w_sin  [SINE_TABLE_DEPTH];
    logic        [11:0] w_tm   [INTENSITY_LEVELS];
    logic        [13:0] w_nw   [INTENSITY_LEVELS];
    logic        [15:0] w_g    [INTENSITY_LEVELS];
    logic        [31:0] w_step [INTENSITY_LEVELS];

    for (genvar gi = 0; gi < CLICK_LENGTH; gi++) begin : g_env
        assign w_env[gi] = f_env(longint'(gi));
    end
    for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_sin
        assign w_sin[gi] = f_sine(longint'(gi));
    end
    for (genvar gi = 0; gi < INTENSITY_LEVELS; gi++) begin : g_coef
        assign w_tm[gi]   = 12'(f_tm(longint'(gi)));
        assign w_nw[gi]   = 14'(f_nw(longint'(gi)));
        assign w_g[gi]    = 16'(f_gain(longint'(gi)));
        assign w_step[gi] = 32'(f_step(longint'(gi)));
    end

    t_state r_state, n_state;
    logic          r_mute, n_mute;
    logic [CW-1:0] r_count, n_count;
    logic [QW-1:0] r_head, n_head;
    logic [QW-1:0] r_tail, n_tail;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_playing, n_playing;
    logic [14:0]   r_prev, n_prev;
    logic [31:0]   r_phase, n_phase;
    logic [14:0]   r_draw, n_draw;
    logic [11:0]   r_tm, n_tm;
    logic [13:0]   r_nw, n_nw;
    logic [15:0]   r_g, n_g;
    logic [31:0]   r_step, n_step;
    logic signed [15:0] r_sin, n_sin;
    logic [15:0]   r_env, n_env;
    logic signed [16:0] r_hp, n_hp;
    logic signed [31:0] r_pa, n_pa;
    logic signed [28:0] r_pb, n_pb;
    logic signed [47:0] r_mix, n_mix;
    logic [47:0]   r_mag, n_mag;
    logic          r_neg, n_neg;
    logic [47:0]   r_t, n_t;
    logic [47:0]   r_u, n_u;
    logic          r_is_click, n_is_click;
    logic          r_res_active, n_res_active;
    logic          r_out_valid, n_out_valid;
    logic signed [15:0] r_out_sample, n_out_sample;
    logic          r_out_active, n_out_active;

    logic          w_we;
    logic [7:0]    w_rdata;
    logic signed [47:0] w_pa_ext, w_pb_ext;
    logic [20:0]   w_v;
    logic signed [15:0] w_sat;

    css_ram #(
        .WIDTH(8),
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_tail),
        .i_wdata(i_intensity),
        .i_raddr(r_head),
        .o_rdata(w_rdata)
    );

    assign w_pa_ext = 48'(r_pa);
    assign w_pb_ext = 48'(r_pb);
    assign w_v = r_u[47:27];

    always_comb begin
        if (r_neg) begin
            w_sat = (w_v > 21'd32768) ? 16'sh8000 : signed'(16'(~w_v + 21'd1));
        end else begin
            w_sat = (w_v > 21'd32767) ? 16'sh7fff : signed'(w_v[15:0]);
        end
    end

    always_comb begin
        logic          v_play;
        logic [IW-1:0] v_idx;
        logic [IW-1:0] v_next;
        n_state = r_state;
        n_mute = r_mute;
        n_count = r_count;
        n_head = r_head;
        n_tail = r_tail;
        n_idx = r_idx;
        n_playing = r_playing;
        n_prev = r_prev;
        n_phase = r_phase;
        n_draw = r_draw;
        n_tm = r_tm;
        n_nw = r_nw;
        n_g = r_g;
        n_step = r_step;
        n_sin = r_sin;
        n_env = r_env;
        n_hp = r_hp;
        n_pa = r_pa;
        n_pb = r_pb;
        n_mix = r_mix;
        n_mag = r_mag;
        n_neg = r_neg;
        n_t = r_t;
        n_u = r_u;
        n_is_click = r_is_click;
        n_res_active = r_res_active;
        n_out_valid = r_out_valid;
        n_out_sample = r_out_sample;
        n_out_active = r_out_active;
        w_we = 1'b0;
        v_play = r_playing;
        v_idx = r_idx;
        v_next = r_idx + 1'b1;
        o_ready = (r_state == S_IDLE);

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_opcode)
                        OP_REQ: begin
                            if (!r_mute && r_count < CW'(QUEUE_DEPTH)) begin
                                w_we = 1'b1;
                                n_tail = (r_tail == QW'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
                                n_count = r_count + 1'b1;
                            end
                        end
                        OP_STOP: begin
                            n_count = '0;
                            n_head = '0;
                            n_tail = '0;
                        end
                        OP_TICK: begin
                            n_draw = i_noise_draw;
                            n_state = S_TICK;
                        end
                        default: ;
                    endcase
                end
            end
            S_TICK: begin
                // start the oldest queued click
                if (!r_playing && r_count != '0) begin
                    n_head = (r_head == QW'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
                    n_count = r_count - 1'b1;
                    n_playing = 1'b1;
                    n_idx = '0;
                    n_phase = '0;
                    n_prev = NOISE_START;
                    n_tm = w_tm[w_rdata];
                    n_nw = w_nw[w_rdata];
                    n_g = w_g[w_rdata];
                    n_step = w_step[w_rdata];
                    v_play = 1'b1;
                    v_idx = '0;
                end
                if (v_play && v_idx < IW'(CLICK_LENGTH)) begin
                    n_state = S_MIX1;
                end else begin
                    n_is_click = 1'b0;
                    n_res_active = v_play;
                    n_state = S_DONE;
                    if (v_play) begin
                        if (v_next >= IW'(CLICK_LENGTH + TAIL_LENGTH)) begin
                            n_playing = 1'b0;
                            n_idx = '0;
                        end else begin
                            n_idx = v_next;
                        end
                    end
                end
            end
            S_MIX1: begin
                n_sin = w_sin[r_phase[31 -: SW]];
                n_env = w_env[r_idx[EW-1:0]];
                n_hp = signed'({2'b00, r_draw}) - signed'({2'b00, r_prev});
                n_prev = r_draw;
                n_phase = r_phase + r_step;
                n_is_click = 1'b1;
                n_res_active = 1'b1;
                if (v_next >= IW'(CLICK_LENGTH + TAIL_LENGTH)) begin
                    n_playing = 1'b0;
                    n_idx = '0;
                end else begin
                    n_idx = v_next;
                end
                n_state = S_MIX2;
            end
            S_MIX2: begin
                n_pa = signed'({1'b0, r_nw}) * r_hp;
                n_pb = signed'({1'b0, r_tm}) * r_sin;
                n_state = S_MIX3;
            end
            S_MIX3: begin
                n_mix = (w_pa_ext <<< 15) + w_pb_ext * 48'sd18000;
                n_state = S_MAG;
            end
            S_MAG: begin
                n_neg = r_mix[47];
                n_mag = r_mix[47] ? 48'(-r_mix) : 48'(r_mix);
                n_state = S_ENV;
            end
            S_ENV: begin
                // split the magnitude so each product stays within 32x16
                n_t = r_mag[47:16] * r_env + ((r_mag[15:0] * r_env) >> 16);
                n_state = S_GAIN;
            end
            S_GAIN: begin
                n_u = r_t[47:16] * r_g + ((r_t[15:0] * r_g) >> 16);
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out_sample = r_is_click ? w_sat : 16'sd0;
                    n_out_active = r_res_active;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (psel && penable && pwrite && paddr == ADDR_MUTE) begin
            n_mute = pwdata[0];
            if (pwdata[0]) begin
                n_count = '0;
                n_head = '0;
                n_tail = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mute <= 1'b0;
            r_count <= '0;
            r_head <= '0;
            r_tail <= '0;
            r_idx <= '0;
            r_playing <= 1'b0;
            r_prev <= '0;
            r_phase <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mute <= n_mute;
            r_count <= n_count;
            r_head <= n_head;
            r_tail <= n_tail;
            r_idx <= n_idx;
            r_playing <= n_playing;
            r_prev <= n_prev;
            r_phase <= n_phase;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_draw <= n_draw;
        r_tm <= n_tm;
        r_nw <= n_nw;
        r_g <= n_g;
        r_step <= n_step;
        r_sin <= n_sin;
        r_env <= n_env;
        r_hp <= n_hp;
        r_pa <= n_pa;
        r_pb <= n_pb;
        r_mix <= n_mix;
        r_mag <= n_mag;
        r_neg <= n_neg;
        r_t <= n_t;
        r_u <= n_u;
        r_is_click <= n_is_click;
        r_res_active <= n_res_active;
        r_out_sample <= n_out_sample;
        r_out_active <= n_out_active;
    end

    assign o_valid = r_out_valid;
    assign o_sample = r_out_sample;
    assign o_click_active = r_out_active;
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MUTE) ? {31'd0, r_mute} : 32'd0;

    `CSS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= CW'(QUEUE_DEPTH))
    `CSS_ASSERT_NOW(a_idle_index, !r_playing, r_idx == '0)
    `CSS_ASSERT_NOW(a_mix_in_click, r_state == S_MIX1, r_playing && r_idx < IW'(CLICK_LENGTH))
    `CSS_ASSERT_NEXT(a_start_pops, r_state == S_TICK && !r_playing && r_count != '0,
                     r_playing && r_idx == '0)

endmodule

>>> tb/tb_click_sound_synthesizer.sv
`timescale 1ns / 100ps
module tb_click_sound_synthesizer;
    import css_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int unsigned FIFO_DEPTH = 16;
    localparam int unsigned CLICK_LEN = 176;
    localparam int unsigned TAIL_LEN = 1764;
    localparam int unsigned SINE_DEPTH = 1024;
    localparam longint unsigned Q30_ONE = 64'd1 << 30;
    localparam longint unsigned TWO_PI_30 = 64'd6746518852;

    typedef struct {
        logic signed [15:0] sample;
        logic               active;
    } t_audio_word;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_opcode = OP_TICK;
    logic [7:0]         i_intensity = '0;
    logic [14:0]        i_noise_draw = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [15:0] o_sample;
    logic               o_click_active;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [APB_AW-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    click_sound_synthesizer DUT (.*);

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb_click_sound_synthesizer: errors");
        $finish;
    end

    // predictor state
    logic [7:0]  fifo_mem [FIFO_DEPTH];
    int unsigned fifo_count;
    logic [3:0]  fifo_head;
    logic [3:0]  fifo_tail;
    int unsigned click_pos;
    bit          click_on;
    logic [14:0] last_noise;
    logic [7:0]  click_level;
    logic [31:0] phase_acc;
    bit          mute_on;
    int signed   sine_lut [SINE_DEPTH];
    longint unsigned env_lut [CLICK_LEN];

    t_audio_word audio_expected [$];
    int          err_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    bit          hold_request = 0;

    function automatic longint unsigned mul_q30(longint unsigned a, longint unsigned b);
        return (a * b) >> 30;
    endfunction

    function automatic int signed sine_value(int unsigned k);
        longint unsigned t, a, x, x2, r, s;
        bit neg;
        t = (longint'(k) << 32) / SINE_DEPTH;
        if (t < (64'd1 << 30)) begin
            a = t; neg = 0;
        end else if (t <= (64'd1 << 31)) begin
            a = (64'd1 << 31) - t; neg = 0;
        end else if (t < (64'd3 << 30)) begin
            a = t - (64'd1 << 31); neg = 1;
        end else begin
            a = (64'd1 << 32) - t; neg = 1;
        end
        x = (a * TWO_PI_30) >> 32;
        x2 = mul_q30(x, x);
        r = Q30_ONE;
        r = Q30_ONE - mul_q30(x2, r) / 110;
        r = Q30_ONE - mul_q30(x2, r) / 72;
        r = Q30_ONE - mul_q30(x2, r) / 42;
        r = Q30_ONE - mul_q30(x2, r) / 20;
        r = Q30_ONE - mul_q30(x2, r) / 6;
        s = (mul_q30(x, r) + (64'd1 << 14)) >> 15;
        if (s > 32767) s = 32767;
        return neg ? -int'(s) : int'(s);
    endfunction

    function automatic longint unsigned envelope_value(int unsigned n);
        longint unsigned z, sum, term, e;
        z = ((64'd11 * n) << 30) / (CLICK_LEN * 16);
        sum = Q30_ONE;
        term = Q30_ONE;
        for (int k = 1; k <= 20; k++) begin
            term = mul_q30(term, z) / k;
            sum += term;
        end
        e = (64'd1 << 60) / sum;
        for (int k = 0; k < 4; k++) e = (e * e + (64'd1 << 29)) >> 30;
        e = (e + (64'd1 << 13)) >> 14;
        return (e > 65535) ? 64'd65535 : e;
    endfunction

    function automatic logic signed [15:0] synth_click_sample(logic [14:0] draw);
        longint unsigned q, g, step, mag, t, v;
        longint signed tm, nw, hp, mix;
        q = click_level;
        tm = 983 + longint'((q * 2949 + 127) / 255);
        nw = ((16384 - tm) * 15565 + 8192) / 16384;
        g = 24576 + (q * 9830 + 127) / 255;
        step = 64'd175304788 + (q * 64'd331131265 + 127) / 255;
        hp = longint'(draw) - longint'(last_noise);
        mix = nw * hp * 32768 + tm * longint'(sine_lut[phase_acc >> 22]) * 18000;
        mag = (mix < 0) ? longint'(-mix) : longint'(mix);
        t = (mag * env_lut[click_pos]) >> 16;
        v = (t * g) >> 43;
        last_noise = draw;
        phase_acc = phase_acc + step[31:0];
        if (mix < 0) return (v > 32768) ? -16'sd32768 : -16'(v);
        return (v > 32767) ? 16'sd32767 : 16'(v);
    endfunction

    function automatic void predict_audio(logic [1:0] op, logic [7:0] q, logic [14:0] draw);
        t_audio_word w;
        case (op)
            OP_REQ: begin
                if (!mute_on && fifo_count < FIFO_DEPTH) begin
                    fifo_mem[fifo_tail] = q;
                    fifo_tail++;
                    fifo_count++;
                end
            end
            OP_STOP: begin
                fifo_count = 0; fifo_head = 0; fifo_tail = 0;
            end
            OP_TICK: begin
                w.sample = 0;
                if (!click_on && fifo_count > 0) begin
                    click_level = fifo_mem[fifo_head];
                    fifo_head++;
                    fifo_count--;
                    click_on = 1;
                    click_pos = 0;
                    phase_acc = 0;
                    last_noise = NOISE_START;
                end
                w.active = click_on;
                if (click_on) begin
                    if (click_pos < CLICK_LEN) w.sample = synth_click_sample(draw);
                    click_pos++;
                    if (click_pos >= CLICK_LEN + TAIL_LEN) begin
                        click_on = 0;
                        click_pos = 0;
                    end
                end
                audio_expected.push_back(w);
            end
            default: ;
        endcase
    endfunction

    task automatic send_word(logic [1:0] op, logic [7:0] q, logic [14:0] draw);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_opcode <= op;
        i_intensity <= q;
        i_noise_draw <= draw;
        do @(posedge i_clk); while (!o_ready);
        predict_audio(op, q, draw);
    endtask

    task automatic drain_and_settle();
        i_valid <= 1'b0;
        while (audio_expected.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_mute(bit val);
        drain_and_settle();
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= ADDR_MUTE; pwdata <= {31'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        mute_on = val;
        if (val) begin
            fifo_count = 0; fifo_head = 0; fifo_tail = 0;
        end
        @(posedge i_clk);
    endtask

    task automatic send_tick();
        logic [14:0] draw;
        draw = ($urandom_range(9) == 0) ? 15'($urandom_range(32767))
                                        : 15'($urandom_range(19999));
        send_word(OP_TICK, 8'($urandom), draw);
    endtask

    // receiver: random ready, long hold on request
    always @(posedge i_clk) begin
        if (o_valid && i_ready) begin
            if (audio_expected.size() == 0) begin
                $error("unexpected word: sample %0d active %0d", o_sample, o_click_active);
                err_count++;
            end else begin
                automatic t_audio_word w = audio_expected.pop_front();
                if (o_sample !== w.sample) begin
                    $error("sample: expected %0d actual %0d", w.sample, o_sample);
                    err_count++;
                end
                if (o_click_active !== w.active) begin
                    $error("click_active: expected %0d actual %0d", w.active, o_click_active);
                    err_count++;
                end
            end
        end
    end

    int unsigned stall_count = 0;
    always @(posedge i_clk) begin
        if (hold_request) begin
            hold_request <= 0;
            stall_count <= 400;
            i_ready <= 1'b0;
        end else if (stall_count != 0) begin
            stall_count <= stall_count - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic test_directed();
        send_word(OP_TICK, 8'd0, 15'd0);
        send_word(OP_UNUSED, 8'hFF, 15'h7FFF);
        send_word(OP_STOP, 8'd0, 15'd0);
        send_word(OP_REQ, 8'd255, 15'd0);
        send_word(OP_REQ, 8'd0, 15'h7FFF);
        send_word(OP_REQ, 8'd128, 15'd0);
        send_word(OP_TICK, 8'd0, 15'd10000);
        send_word(OP_TICK, 8'd0, 15'd0);
        send_word(OP_TICK, 8'd0, 15'd19999);
        send_word(OP_TICK, 8'hFF, 15'h7FFF);
        send_word(OP_TICK, 8'd0, 15'd0);
        send_word(OP_STOP, 8'd0, 15'd0);
        send_word(OP_UNUSED, 8'd0, 15'd0);
        repeat (8) send_word(OP_TICK, 8'd0, 15'($urandom_range(1) ? 32767 : 0));
    endtask

    task automatic test_queue_full();
        send_word(OP_STOP, 8'd0, 15'd0);
        repeat (20) send_word(OP_REQ, 8'($urandom), 15'($urandom));
        repeat (30) send_tick();
    endtask

    task automatic test_mute();
        send_word(OP_REQ, 8'd200, 15'd0);
        write_mute(1'b1);
        repeat (4) send_word(OP_REQ, 8'($urandom), 15'd0);
        repeat (4) send_tick();
        write_mute(1'b0);
        repeat (3) send_word(OP_REQ, 8'($urandom), 15'd0);
        repeat (4) send_tick();
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request = 1;
        repeat (40) send_tick();
    endtask

    task automatic test_random_traffic(int unsigned count);
        int unsigned pick;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 84) send_tick();
            else if (pick < 95) send_word(OP_REQ, 8'($urandom), 15'($urandom));
            else if (pick < 98) send_word(OP_STOP, 8'($urandom), 15'($urandom));
            else send_word(OP_UNUSED, 8'($urandom), 15'($urandom));
        end
    endtask

    initial begin
        for (int k = 0; k < SINE_DEPTH; k++) sine_lut[k] = sine_value(k);
        for (int n = 0; n < CLICK_LEN; n++) env_lut[n] = envelope_value(n);
        fifo_count = 0; fifo_head = 0; fifo_tail = 0;
        click_pos = 0; click_on = 0; last_noise = 0; click_level = 0;
        phase_acc = 0; mute_on = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_queue_full();
        test_mute();
        test_backpressure();
        send_idle_pct = 26; recv_idle_pct = 86;
        test_random_traffic(520);
        write_mute(1'b1);
        test_random_traffic(40);
        write_mute(1'b0);
        send_idle_pct = 86; recv_idle_pct = 26;
        test_random_traffic(520);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random_traffic(520);

        i_valid <= 1'b0;
        while (audio_expected.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_click_sound_synthesizer: clean");
        end else begin
            $display("tb_click_sound_synthesizer: errors");
        end
        $finish;
    end

endmodule
